FILE: hdl/sitda_pkg.sv
`default_nettype none

package sitda_pkg;

  localparam int DEFAULT_VALUE_BITS = 32;
  localparam int CALC_W             = 64;
  localparam int RADIX              = 10;
  localparam int QUEUE_DEPTH        = 2;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  // Number of decimal digits in the largest magnitude, 2^(bits-1).
  function automatic int max_digits(input int bits);
    logic [CALC_W-1:0] m;
    int n;
    m = CALC_W'(1) << (bits - 1);
    n = 0;
    for (int i = 0; i < 20; i++) begin
      if (m != '0) begin
        m = m / RADIX;
        n = n + 1;
      end
    end
    return n;
  endfunction

  function automatic logic [CALC_W-1:0] pow10(input int k);
    logic [CALC_W-1:0] p;
    p = CALC_W'(1);
    for (int i = 0; i < 19; i++) begin
      if (i < k) begin
        p = p * CALC_W'(RADIX);
      end
    end
    return p;
  endfunction

  // Weight of digit value d at decimal position k.
  function automatic logic [CALC_W-1:0] digit_weight(input int d, input int k);
    return pow10(k) * CALC_W'(d);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/sitda_front.sv
`default_nettype none

module sitda_front #(
  parameter int VALUE_BITS = sitda_pkg::DEFAULT_VALUE_BITS,
  parameter int KW         = 5
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [VALUE_BITS-1:0] in_value,
  output logic                              push_valid,
  input  wire logic                         push_ready,
  output logic                              push_neg,
  output logic             [VALUE_BITS-1:0] push_mag,
  output logic             [KW-1:0]         push_top
);
  import sitda_pkg::*;

  localparam int MAXD = max_digits(VALUE_BITS);

  logic                  vld_r;
  logic                  neg_r;
  logic [VALUE_BITS-1:0] mag_r;
  logic                  neg_nxt;
  logic [VALUE_BITS-1:0] mag_nxt;
  logic [CALC_W-1:0]     mag_ext;
  logic [KW-1:0]         top;

  assign in_ready = !vld_r || push_ready;
  assign neg_nxt  = in_value[VALUE_BITS-1];
  assign mag_nxt  = neg_nxt ? (~in_value + VALUE_BITS'(1)) : in_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      neg_r <= neg_nxt;
      mag_r <= mag_nxt;
    end
  end

  // The index of the leading digit is the highest power of ten not above the magnitude.
  assign mag_ext = CALC_W'(mag_r);

  always_comb begin
    top = '0;
    for (int k = 1; k < MAXD; k++) begin
      if (mag_ext >= pow10(k)) begin
        top = KW'(k);
      end
    end
  end

  assign push_valid = vld_r;
  assign push_neg   = neg_r;
  assign push_mag   = mag_r;
  assign push_top   = top;

endmodule

`default_nettype wire

FILE: hdl/sitda_queue.sv
`default_nettype none

module sitda_queue #(
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_valid,
  output logic                   wr_ready,
  input  wire logic [DATA_W-1:0] wr_data,
  output logic                   rd_valid,
  input  wire logic              rd_ready,
  output logic      [DATA_W-1:0] rd_data
);
  import sitda_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] mem [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     rd_ptr_r;
  logic [CW-1:0]     cnt_r;
  logic              do_wr;
  logic              do_rd;

  assign wr_ready = (cnt_r != CW'(QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sitda_back.sv
`default_nettype none

module sitda_back #(
  parameter int VALUE_BITS = sitda_pkg::DEFAULT_VALUE_BITS,
  parameter int KW         = 5
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  pop_valid,
  output logic                       pop_ready,
  input  wire logic                  pop_neg,
  input  wire logic [VALUE_BITS-1:0] pop_mag,
  input  wire logic [KW-1:0]         pop_top,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [7:0]            out_character,
  output logic                       out_last
);
  import sitda_pkg::*;

  localparam int MAXD = max_digits(VALUE_BITS);

  logic                  busy_r;
  logic                  sign_r;
  logic [VALUE_BITS-1:0] rem_r;
  logic [KW-1:0]         k_r;
  logic                  out_valid_r;
  logic [7:0]            char_r;
  logic                  last_r;

  logic                  advance;
  logic [CALC_W-1:0]     rem_ext;
  logic [CALC_W-1:0]     mult [RADIX];
  logic [3:0]            digit;
  logic [CALC_W-1:0]     weight;
  logic [VALUE_BITS-1:0] rem_nxt;

  assign pop_ready = !busy_r;
  assign advance   = busy_r && (!out_valid_r || out_ready);
  assign rem_ext   = CALC_W'(rem_r);

  // The multiples of the current power of ten are picked from a constant table.
  // Each digit is the largest multiple that still fits.
  always_comb begin
    for (int m = 0; m < RADIX; m++) begin
      mult[m] = '0;
      for (int j = 0; j < MAXD; j++) begin
        if (int'(k_r) == j) begin
          mult[m] = digit_weight(m, j);
        end
      end
    end
    digit = '0;
    for (int m = 1; m < RADIX; m++) begin
      if (rem_ext >= mult[m]) begin
        digit = 4'(m);
      end
    end
    weight  = mult[digit];
    rem_nxt = rem_r - weight[VALUE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!busy_r) begin
        busy_r <= pop_valid;
      end else if (advance && !sign_r && (k_r == '0)) begin
        busy_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r) begin
      sign_r <= pop_neg;
      rem_r  <= pop_mag;
      k_r    <= pop_top;
    end else if (advance) begin
      if (sign_r) begin
        sign_r <= 1'b0;
      end else begin
        rem_r <= rem_nxt;
        k_r   <= k_r - KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (sign_r) begin
        char_r <= ASCII_MINUS;
        last_r <= 1'b0;
      end else begin
        char_r <= ASCII_ZERO + {4'b0000, digit};
        last_r <= (k_r == '0);
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = char_r;
  assign out_last      = last_r;

endmodule

`default_nettype wire

FILE: hdl/signed_int_to_decimal_ascii.sv
`default_nettype none

// Converts each signed two's-complement value into its decimal text, sent as one ASCII
// character per transfer, most significant first, with a leading minus sign for negative
// values, no leading zeros, and out_last set on the final character; the most negative
// value converts exactly. For each number the output stage first loads the digit generator,
// then sends one character per cycle while out_ready allows, each digit found by comparing
// the remainder against the nine multiples of the current power of ten. The input stage
// works out the sign, magnitude and leading-digit position and holds up to two further
// numbers in a queue, so it keeps taking values while characters are still being sent,
// until that queue is full.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = sitda_pkg::DEFAULT_VALUE_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [VALUE_BITS-1:0] in_value,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic             [7:0]            out_character,
  output logic                              out_last
);
  import sitda_pkg::*;

  localparam int MAXD   = max_digits(VALUE_BITS);
  localparam int KW     = (MAXD > 1) ? $clog2(MAXD) : 1;
  localparam int DATA_W = 1 + VALUE_BITS + KW;

  logic                  push_valid;
  logic                  push_ready;
  logic                  push_neg;
  logic [VALUE_BITS-1:0] push_mag;
  logic [KW-1:0]         push_top;
  logic                  pop_valid;
  logic                  pop_ready;
  logic [DATA_W-1:0]     pop_data;

  sitda_front #(
    .VALUE_BITS (VALUE_BITS),
    .KW         (KW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_value   (in_value),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_neg   (push_neg),
    .push_mag   (push_mag),
    .push_top   (push_top)
  );

  sitda_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  ({push_neg, push_mag, push_top}),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_data)
  );

  sitda_back #(
    .VALUE_BITS (VALUE_BITS),
    .KW         (KW)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_neg       (pop_data[DATA_W-1]),
    .pop_mag       (pop_data[DATA_W-2:KW]),
    .pop_top       (pop_data[KW-1:0]),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire
